// ===== sv/grtt_pkg.sv =====
`timescale 1ns / 1ps

package grtt_pkg;

  localparam int unsigned MapSizeLog2Def = 6;
  localparam int unsigned FracBitsDef    = 8;

  localparam int unsigned StepsW        = 13;
  localparam logic [StepsW-1:0] StepsRst = 13'd4096;

  localparam int unsigned TW32          = 32;
  localparam logic [TW32-1:0] TInf      = 32'hFFFF_FFFF;
  localparam logic [TW32-1:0] TOne      = 32'h0001_0000;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 24;

  localparam int unsigned RegMaxSteps = 0;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StSetup,
    StDiv,
    StWalk,
    StCheck,
    StFin
  } state_e;

endpackage

// ===== sv/grid_ray_tile_traversal_unit.sv =====
`timescale 1ns / 1ps

// Grid ray traversal over a one-bit tile map. A word with tuser 0 writes one tile; a word
// with tuser 1 casts a segment and yields one result word. Unless the segment has zero
// length, a cast runs four divisions in one shared bit-serial divider (two reciprocals
// and the t to the first tile edges), then walks with a step and a tile map read per
// tile step; the map read port sets the step rate.
// After reset all 2^(2*MAP_SIZE_LOG2) tile map cells are cleared, and no word is
// accepted until the clear is done.
module grid_ray_tile_traversal_unit #(
  parameter int unsigned MAP_SIZE_LOG2 = grtt_pkg::MapSizeLog2Def,
  parameter int unsigned FRAC_BITS     = grtt_pkg::FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tile_x[5:0], tile_y[11:6], tile_solid[12], start_x[28:13], start_y[44:29],
  // end_x[60:45], end_y[76:61], zero fill above
  input  logic [grtt_pkg::InDataW-1:0] s_axis_tdata,
  // cmd[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // hit_tile_x[8:0], hit_tile_y[17:9], zero fill above
  output logic [grtt_pkg::OutDataW-1:0] m_axis_tdata,
  // hit[0]
  output logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned M      = MAP_SIZE_LOG2;
  localparam int unsigned F      = FRAC_BITS;
  localparam int unsigned AW     = 2 * M;
  localparam int unsigned Cells  = 1 << AW;
  localparam int unsigned NW     = F + 17;
  localparam int unsigned BW     = $clog2(NW);
  localparam int unsigned TW     = (18 - F > 10) ? 18 - F : 10;
  localparam int unsigned WB     = (M < 6) ? M : 6;
  localparam int unsigned SW     = grtt_pkg::StepsW;

  // Configuration.
  logic [SW-1:0] max_steps_q;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32-SW){1'b0}}, max_steps_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_steps_q <= grtt_pkg::StepsRst;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == 1'(grtt_pkg::RegMaxSteps)) begin
      max_steps_q <= pwdata[SW-1:0];
    end
  end

  // Tile map.
  logic          mem [Cells];
  logic          mem_we, mem_wd, mem_re, mem_rd_q;
  logic [AW-1:0] mem_wa, mem_ra;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rd_q <= mem[mem_ra];
    end
  end

  grtt_pkg::state_e state_q, state_d;
  logic [AW-1:0]    clr_q;

  logic signed [15:0] ax_q, ay_q, bx_q, by_q;
  logic signed [TW-1:0] tx_q, ty_q, ex_q, ey_q;
  logic          sx_q, sy_q;             // 1 means step up
  logic          zx_q, zy_q;             // axis without motion
  logic [16:0]   magx_q, magy_q;
  logic [F:0]    distx_q, disty_q;
  logic [31:0]   nx_q, ny_q, dx_q, dy_q;
  logic [1:0]    ph_q;
  logic [BW-1:0] bit_q;
  logic [NW-1:0] num_q;
  logic [17:0]   rem_q;
  logic [SW-1:0] cnt_q;
  logic          hit_q;
  logic [8:0]    hx_q, hy_q;

  logic          out_vld_q, out_hit_q;
  logic [8:0]    out_hx_q, out_hy_q;

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Setup combinational values.
  logic signed [16:0] dxs, dys;
  logic signed [TW-1:0] tx0, ty0;
  assign dxs = 17'(bx_q) - 17'(ax_q);
  assign dys = 17'(by_q) - 17'(ay_q);
  assign tx0 = TW'(ax_q >>> F);
  assign ty0 = TW'(ay_q >>> F);

  // Divider step.
  logic [17:0] rem_sh, rem_sub;
  logic [16:0] den;
  logic        qbit;
  assign den     = ph_q[1] ? magy_q : magx_q;
  assign rem_sh  = {rem_q[16:0], num_q[NW-1]};
  assign qbit    = rem_sh >= {1'b0, den};
  assign rem_sub = qbit ? rem_sh - {1'b0, den} : rem_sh;

  logic [NW-1:0] quo;
  assign quo = {num_q[NW-2:0], qbit};

  function automatic logic [NW-1:0] load_num(input logic [1:0] ph, input logic [F:0] dxn,
                                              input logic [F:0] dyn);
    logic [NW-1:0] r;
    r = '0;
    case (ph)
      2'd0, 2'd2: r[NW-1] = 1'b1;
      2'd1:       r = {dxn, 16'd0};
      2'd3:       r = {dyn, 16'd0};
      default:    r = '0;
    endcase
    return r;
  endfunction

  // Walk step combinational values.
  logic          go_x;
  logic [31:0]   t_sel;
  logic signed [TW-1:0] ntx, nty;
  logic          outside;
  logic [32:0]   sum_x, sum_y;
  assign go_x  = nx_q < ny_q;
  assign t_sel = go_x ? nx_q : ny_q;
  assign ntx   = go_x ? (sx_q ? tx_q + TW'(1) : tx_q - TW'(1)) : tx_q;
  assign nty   = go_x ? ty_q : (sy_q ? ty_q + TW'(1) : ty_q - TW'(1));
  assign outside = (ntx[TW-1:M] != '0) || (nty[TW-1:M] != '0);
  assign sum_x = {1'b0, nx_q} + {1'b0, dx_q};
  assign sum_y = {1'b0, ny_q} + {1'b0, dy_q};

  logic walk_end;
  assign walk_end = (cnt_q == max_steps_q) || (tx_q == ex_q && ty_q == ey_q) ||
                    (t_sel > grtt_pkg::TOne);

  logic out_free;
  assign out_free = !out_vld_q || m_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      grtt_pkg::StClear: if (clr_q == AW'(Cells - 1)) state_d = grtt_pkg::StIdle;
      grtt_pkg::StIdle:  if (in_acc && s_axis_tuser) state_d = grtt_pkg::StSetup;
      grtt_pkg::StSetup: begin
        if (dxs == '0 && dys == '0) state_d = grtt_pkg::StFin;
        else                        state_d = grtt_pkg::StDiv;
      end
      grtt_pkg::StDiv:   if (bit_q == BW'(NW - 1) && ph_q == 2'd3) state_d = grtt_pkg::StWalk;
      grtt_pkg::StWalk: begin
        if (walk_end || outside) state_d = grtt_pkg::StFin;
        else                     state_d = grtt_pkg::StCheck;
      end
      grtt_pkg::StCheck: state_d = mem_rd_q ? grtt_pkg::StFin : grtt_pkg::StWalk;
      grtt_pkg::StFin:   if (out_free) state_d = grtt_pkg::StIdle;
      default:           state_d = grtt_pkg::StClear;
    endcase
  end

  // Outputs and memory controls.
  always_comb begin
    s_axis_tready = (state_q == grtt_pkg::StIdle);
    mem_we = 1'b0;
    mem_wd = 1'b0;
    mem_wa = {M'(s_axis_tdata[6+WB-1:6]), M'(s_axis_tdata[WB-1:0])};
    mem_re = (state_q == grtt_pkg::StWalk) && !walk_end && !outside;
    mem_ra = {nty[M-1:0], ntx[M-1:0]};
    case (state_q)
      grtt_pkg::StClear: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
      end
      grtt_pkg::StIdle: begin
        mem_we = in_acc && !s_axis_tuser;
        mem_wd = s_axis_tdata[12];
      end
      default: mem_we = 1'b0;
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = {6'd0, out_hy_q, out_hx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= grtt_pkg::StClear;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == grtt_pkg::StClear) clr_q <= clr_q + 1'b1;
      if (state_q == grtt_pkg::StFin && out_free) out_vld_q <= 1'b1;
      else if (m_axis_tready)                     out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ax_q <= s_axis_tdata[28:13];
      ay_q <= s_axis_tdata[44:29];
      bx_q <= s_axis_tdata[60:45];
      by_q <= s_axis_tdata[76:61];
    end
    case (state_q)
      grtt_pkg::StSetup: begin
        tx_q    <= tx0;
        ty_q    <= ty0;
        ex_q    <= TW'(bx_q >>> F);
        ey_q    <= TW'(by_q >>> F);
        sx_q    <= dxs > 0;
        sy_q    <= dys > 0;
        zx_q    <= dxs == '0;
        zy_q    <= dys == '0;
        magx_q  <= dxs[16] ? 17'(-dxs) : 17'(dxs);
        magy_q  <= dys[16] ? 17'(-dys) : 17'(dys);
        distx_q <= (dxs > 0) ? (F+1)'(1 << F) - {1'b0, ax_q[F-1:0]} : {1'b0, ax_q[F-1:0]};
        disty_q <= (dys > 0) ? (F+1)'(1 << F) - {1'b0, ay_q[F-1:0]} : {1'b0, ay_q[F-1:0]};
        ph_q    <= 2'd0;
        bit_q   <= '0;
        rem_q   <= '0;
        num_q   <= load_num(2'd0, '0, '0);
        cnt_q   <= '0;
        hit_q   <= 1'b0;
        hx_q    <= '0;
        hy_q    <= '0;
      end
      grtt_pkg::StDiv: begin
        if (bit_q == BW'(NW - 1)) begin
          case (ph_q)
            2'd0:    dx_q <= zx_q ? grtt_pkg::TInf : 32'(quo);
            2'd1:    nx_q <= zx_q ? grtt_pkg::TInf : 32'(quo);
            2'd2:    dy_q <= zy_q ? grtt_pkg::TInf : 32'(quo);
            default: ny_q <= zy_q ? grtt_pkg::TInf : 32'(quo);
          endcase
          ph_q  <= ph_q + 2'd1;
          bit_q <= '0;
          rem_q <= '0;
          num_q <= load_num(ph_q + 2'd1, distx_q, disty_q);
        end else begin
          bit_q <= bit_q + 1'b1;
          rem_q <= rem_sub;
          num_q <= quo;
        end
      end
      grtt_pkg::StWalk: begin
        if (!walk_end) begin
          cnt_q <= cnt_q + 1'b1;
          tx_q  <= ntx;
          ty_q  <= nty;
          if (go_x) nx_q <= sum_x[32] ? grtt_pkg::TInf : sum_x[31:0];
          else      ny_q <= sum_y[32] ? grtt_pkg::TInf : sum_y[31:0];
          if (outside) begin
            hit_q <= 1'b1;
            hx_q  <= ntx[8:0];
            hy_q  <= nty[8:0];
          end
        end
      end
      grtt_pkg::StCheck: begin
        if (mem_rd_q) begin
          hit_q <= 1'b1;
          hx_q  <= tx_q[8:0];
          hy_q  <= ty_q[8:0];
        end
      end
      grtt_pkg::StFin: begin
        if (out_free) begin
          out_hit_q <= hit_q;
          out_hx_q  <= hx_q;
          out_hy_q  <= hy_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
